/* rtl/aescbc_pkg.sv */
// Shared types, constants and byte-level functions of the AES-128 CBC encryptor.
package aescbc_pkg;

    localparam int BlockW   = 128;
    localparam int HalfW    = 64;
    localparam int CfgAddrW = 3;
    localparam int NumRounds = 10;

    // Configuration register indexes.
    typedef enum logic [CfgAddrW-1:0] {
        CFG_KEY_HIGH   = 3'd0,
        CFG_KEY_LOW    = 3'd1,
        CFG_IV_HIGH    = 3'd2,
        CFG_IV_LOW     = 3'd3,
        CFG_CHAIN_MODE = 3'd4
    } t_cfg_addr;

    typedef struct packed {
        logic [HalfW-1:0] block_high;
        logic [HalfW-1:0] block_low;
        logic             restart;
    } t_in_req;

    typedef struct packed {
        logic [HalfW-1:0] cipher_high;
        logic [HalfW-1:0] cipher_low;
    } t_out_req;

    typedef logic [NumRounds:0][BlockW-1:0] t_round_keys;

    localparam logic [7:0] GfPoly  = 8'h1B;
    localparam logic [7:0] GfTopBit = 8'h80;

    localparam logic [7:0] RCON [NumRounds+1] = '{
        8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
        8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
    };

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] sub_byte(input logic [7:0] b);
        return SBOX[b];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sub_byte(w[31:24]), sub_byte(w[23:16]), sub_byte(w[15:8]), sub_byte(w[7:0])};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (((b & GfTopBit) != 8'h00) ? GfPoly : 8'h00);
    endfunction

    // One column of MixColumns; byte 0 of the column sits in the top bits.
    function automatic logic [31:0] mix_column(input logic [31:0] col);
        logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
        a0 = col[31:24];
        a1 = col[23:16];
        a2 = col[15:8];
        a3 = col[7:0];
        d0 = xtime(a0);
        d1 = xtime(a1);
        d2 = xtime(a2);
        d3 = xtime(a3);
        return {d0 ^ d1 ^ a1 ^ a2 ^ a3,
                a0 ^ d1 ^ d2 ^ a2 ^ a3,
                a0 ^ a1 ^ d2 ^ d3 ^ a3,
                d0 ^ a0 ^ a1 ^ a2 ^ d3};
    endfunction

endpackage

/* rtl/aes128_cbc_encrypt.sv */
// Top level of the AES-128 encryptor with optional CBC chaining.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_req) carries one plaintext
//   block and a restart flag per request; output channel (o_out_valid /
//   i_out_stall / o_out_req) returns one ciphertext block per request, in order.
//   Key, IV and chain mode are written through the configuration port while
//   no request is in flight; a new key is usable once the key schedule has registered it.
// Timing:
//   A request accepted at one clock edge sits in the input register; all ten
//   rounds are computed combinationally from it, and the ciphertext is loaded
//   into the output register once that register is free, raising o_out_valid.
//   One request per cycle is sustained while the output is not stalled: the chain value for
//   the next block is written at the same edge as the ciphertext. The period
//   is set by the ten unrolled rounds between the two registers.
// Reset:
//   Both channels empty, key and IV zero, CBC mode selected, chain value zero.
// Back-pressure:
//   While i_out_stall holds a full output register, the input register still
//   takes one more request; o_in_stall rises only when both registers are full.
module aes128_cbc_encrypt
    import aescbc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [HalfW-1:0]    i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_req             i_in_req,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_req            o_out_req
);

    logic [HalfW-1:0]  r_key_high, r_key_low, r_iv_high, r_iv_low;
    logic              r_chain_mode;
    logic [BlockW-1:0] r_chain, n_chain;
    logic              r_in_valid, n_in_valid;
    t_in_req           r_in;
    logic              r_out_valid, n_out_valid;
    t_out_req          r_out;

    logic              in_accept;
    logic              advance;
    logic [BlockW-1:0] chain_src;
    logic [BlockW-1:0] cipher;
    t_round_keys       round_keys;
    logic [NumRounds:0][BlockW-1:0] round_state;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high   <= '0;
            r_key_low    <= '0;
            r_iv_high    <= '0;
            r_iv_low     <= '0;
            r_chain_mode <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_KEY_HIGH:   r_key_high   <= i_cfg_wdata;
                CFG_KEY_LOW:    r_key_low    <= i_cfg_wdata;
                CFG_IV_HIGH:    r_iv_high    <= i_cfg_wdata;
                CFG_IV_LOW:     r_iv_low     <= i_cfg_wdata;
                CFG_CHAIN_MODE: r_chain_mode <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    aescbc_key_expand u_key_expand (
        .i_clk        (i_clk),
        .i_key        ({r_key_high, r_key_low}),
        .o_round_keys (round_keys)
    );

    // Handshake: the input register moves on whenever the output register is free.
    assign advance    = r_in_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_in_valid & r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;

    // Restart reloads the chain from the IV before the block is used.
    assign chain_src = r_in.restart ? {r_iv_high, r_iv_low} : r_chain;

    assign round_state[0] = {r_in.block_high, r_in.block_low}
                            ^ (r_chain_mode ? chain_src : {BlockW{1'b0}})
                            ^ round_keys[0];

    for (genvar g = 1; g <= NumRounds; g++) begin : g_round
        aescbc_round u_round (
            .i_state     (round_state[g-1]),
            .i_round_key (round_keys[g]),
            .i_last      (g == NumRounds),
            .o_state     (round_state[g])
        );
    end

    assign cipher = round_state[NumRounds];

    always_comb begin
        n_in_valid  = in_accept ? 1'b1 : (advance ? 1'b0 : r_in_valid);
        n_out_valid = advance ? 1'b1 : (r_out_valid & i_out_stall);
        n_chain     = r_chain;
        if (advance) begin
            if (r_chain_mode) begin
                n_chain = cipher;
            end else if (r_in.restart) begin
                n_chain = {r_iv_high, r_iv_low};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_chain     <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_chain     <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_req;
        end
        if (advance) begin
            r_out.cipher_high <= cipher[BlockW-1:HalfW];
            r_out.cipher_low  <= cipher[HalfW-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

/* rtl/aescbc_key_expand.sv */
// Key schedule: expands the cipher key into the eleven round keys, held in registers.
module aescbc_key_expand
    import aescbc_pkg::*;
(
    input  logic              i_clk,
    input  logic [BlockW-1:0] i_key,
    output t_round_keys       o_round_keys
);

    t_round_keys r_round_keys;
    t_round_keys n_round_keys;

    always_comb begin
        logic [31:0] w0, w1, w2, w3, prev3;
        n_round_keys[0] = i_key;
        for (int rnd = 1; rnd <= NumRounds; rnd++) begin
            prev3 = n_round_keys[rnd-1][31:0];
            w0 = n_round_keys[rnd-1][127:96]
                 ^ sub_word({prev3[23:0], prev3[31:24]})
                 ^ {RCON[rnd], 24'h000000};
            w1 = n_round_keys[rnd-1][95:64] ^ w0;
            w2 = n_round_keys[rnd-1][63:32] ^ w1;
            w3 = n_round_keys[rnd-1][31:0]  ^ w2;
            n_round_keys[rnd] = {w0, w1, w2, w3};
        end
    end

    // Loaded each cycle; user changes key only with no block in flight; unenforced.
    always_ff @(posedge i_clk) begin
        r_round_keys <= n_round_keys;
    end

    assign o_round_keys = r_round_keys;

endmodule

/* rtl/aescbc_round.sv */
// One AES round: SubBytes, ShiftRows, MixColumns (skipped in the last round), AddRoundKey.
module aescbc_round
    import aescbc_pkg::*;
(
    input  logic [BlockW-1:0] i_state,
    input  logic [BlockW-1:0] i_round_key,
    input  logic              i_last,
    output logic [BlockW-1:0] o_state
);

    logic [BlockW-1:0] shifted;
    logic [BlockW-1:0] mixed;

    // State byte 4*c+r is row r of column c; byte 0 is the most significant.
    always_comb begin
        int src;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = 4 * ((c + r) & 3) + r;
                shifted[BlockW-1-8*(4*c+r) -: 8] = sub_byte(i_state[BlockW-1-8*src -: 8]);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            mixed[BlockW-1-32*c -: 32] = mix_column(shifted[BlockW-1-32*c -: 32]);
        end
    end

    assign o_state = (i_last ? shifted : mixed) ^ i_round_key;

endmodule

/* rtl/aescbc_checker.sv */
// Port-level checks of the AES-128 CBC encryptor, bound to its top level.
module aescbc_checker
    import aescbc_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input t_out_req            o_out_req
);

    // A stalled result stays offered and unchanged.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_req))
        else $error("stalled result dropped or changed");

    // The input side only stalls while the output register holds a stalled result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with room to spare");

    // A newly valid result comes from a request taken via the input register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result without a request");

    // Reset empties the output channel.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind aes128_cbc_encrypt aescbc_checker u_checker (.*);
